FILE: rtl/lmsp_pkg.sv
`timescale 1ns / 1ps
// Package for the LED matrix scan/PWM driver: payload types and fixed widths.
// No dependencies.
package lmsp_pkg;

	localparam int PIXEL_W = 15;
	localparam int RGB_W   = 6;
	localparam int ROW_W   = 4;
	localparam int LANE_W  = 3;

	typedef logic [PIXEL_W-1:0] pixel_t;
	typedef logic [RGB_W-1:0]   rgb_t;
	typedef logic [ROW_W-1:0]   row_t;
	typedef logic [LANE_W-1:0]  lane_bits_t;

	typedef struct packed {
		rgb_t rgb_bits;
		row_t row_address;
		logic latch_row;
		logic blanked;
	} result_t;

endpackage

FILE: rtl/lmsp_pixel_if.sv
`timescale 1ns / 1ps
// Input channel: one column of upper and lower pixels plus last-column flag.
// Depends on lmsp_pkg.
interface lmsp_pixel_if;
	logic             valid;
	logic             ready;
	lmsp_pkg::pixel_t upper_pixel;
	lmsp_pkg::pixel_t lower_pixel;
	logic             last_column;

	modport source(output valid, output upper_pixel, output lower_pixel,
		output last_column, input ready);
	modport sink(input valid, input upper_pixel, input lower_pixel,
		input last_column, output ready);
endinterface

FILE: rtl/lmsp_result_if.sv
`timescale 1ns / 1ps
// Output channel: six data bits, row address, latch and blank flags.
// Depends on lmsp_pkg.
interface lmsp_result_if;
	logic           valid;
	logic           ready;
	lmsp_pkg::rgb_t rgb_bits;
	lmsp_pkg::row_t row_address;
	logic           latch_row;
	logic           blanked;

	modport source(output valid, output rgb_bits, output row_address,
		output latch_row, output blanked, input ready);
	modport sink(input valid, input rgb_bits, input row_address,
		input latch_row, input blanked, output ready);
endinterface

FILE: rtl/lmsp_cfg_if.sv
`timescale 1ns / 1ps
// Configuration write channel carrying the scan_enable bit.
// No dependencies.
interface lmsp_cfg_if;
	logic valid;
	logic ready;
	logic data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

FILE: rtl/led_matrix_scan_pwm_unit.sv
`timescale 1ns / 1ps
// Scan/PWM driver for a row-multiplexed RGB LED matrix.
// Channels: pix (input columns), res (output bits), cfg (scan_enable write).
// Results are registered and appear on res in the cycle after a pix transfer.
// Throughput: one column per cycle unless res stalls. Two pixel lanes compare
// in parallel; the merge stage registers the combined result, row and flags.
// The scan counter holds the row in its high bits and the slice in its low
// COLOR_BITS bits; it steps on each last-column transfer while enabled and
// wraps after SCAN_ROWS * 2^COLOR_BITS steps.
// Reset: counter and scan_enable clear, output register empty.
// While scan_enable is 0 results come out blanked and the counter holds.
// Stall: the output register holds its result while res.ready is low, and
// pix.ready follows, so a new column is taken in the same cycle the held
// result is transferred.
// cfg.ready is always high; writes are expected only while the block is idle.
// Depends on lmsp_pkg, lmsp_pixel_if, lmsp_result_if, lmsp_cfg_if, lmsp_lane.
module led_matrix_scan_pwm_unit #(
	parameter int COLOR_BITS = 5,
	parameter int SCAN_ROWS  = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	lmsp_pixel_if.sink       pix,
	lmsp_result_if.source    res,
	lmsp_cfg_if.sink         cfg
);

	localparam int ROW_BITS = (SCAN_ROWS > 1) ? $clog2(SCAN_ROWS) : 1;
	localparam int CNT_W    = ROW_BITS + COLOR_BITS;
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'((SCAN_ROWS << COLOR_BITS) - 1);

	logic                 scan_en_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 out_valid_q;
	lmsp_pkg::result_t    out_s1;
	lmsp_pkg::lane_bits_t upper_lit;
	lmsp_pkg::lane_bits_t lower_lit;
	logic [COLOR_BITS-1:0] slice;
	logic [31:0]          row_wide;
	lmsp_pkg::result_t    merged;
	logic                 in_xfer;

	assign slice    = cnt_q[COLOR_BITS-1:0];
	assign row_wide = 32'(cnt_q >> COLOR_BITS);

	lmsp_lane #(.COLOR_BITS(COLOR_BITS)) u_lane_upper (
		.pixel (pix.upper_pixel),
		.slice (slice),
		.lit   (upper_lit)
	);

	lmsp_lane #(.COLOR_BITS(COLOR_BITS)) u_lane_lower (
		.pixel (pix.lower_pixel),
		.slice (slice),
		.lit   (lower_lit)
	);

	always_comb begin
		merged.rgb_bits    = scan_en_q ? {lower_lit, upper_lit} : '0;
		merged.row_address = row_wide[lmsp_pkg::ROW_W-1:0];
		merged.latch_row   = scan_en_q & pix.last_column;
		merged.blanked     = ~scan_en_q;
	end

	assign pix.ready = ~out_valid_q | res.ready;
	assign in_xfer   = pix.valid & pix.ready;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_en_q <= 1'b0;
		end else if (cfg.valid) begin
			scan_en_q <= cfg.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (in_xfer && scan_en_q && pix.last_column) begin
			if (cnt_q == CNT_MAX) begin
				cnt_q <= '0;
			end else begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pix.ready) begin
			out_valid_q <= pix.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			out_s1 <= merged;
		end
	end

	assign res.valid       = out_valid_q;
	assign res.rgb_bits    = out_s1.rgb_bits;
	assign res.row_address = out_s1.row_address;
	assign res.latch_row   = out_s1.latch_row;
	assign res.blanked     = out_s1.blanked;

`ifndef SYNTH
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_MAX)
		else $error("scan counter out of range");

	a_cnt_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!scan_en_q |=> $stable(cnt_q))
		else $error("scan counter moved while disabled");

	a_latch_not_blank: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.latch_row |-> !res.blanked)
		else $error("latch asserted on blanked result");

	a_blank_dark: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.blanked |-> res.rgb_bits == '0)
		else $error("blanked result has lit bits");
`endif

endmodule

FILE: rtl/lmsp_lane.sv
`timescale 1ns / 1ps
// One pixel lane: unpacks R/G/B and compares each against the current slice.
// Depends on lmsp_pkg.
module lmsp_lane #(
	parameter int COLOR_BITS = 5
) (
	input  lmsp_pkg::pixel_t     pixel,
	input  logic [COLOR_BITS-1:0] slice,
	output lmsp_pkg::lane_bits_t lit
);

	localparam int EXT_W = (3 * COLOR_BITS > lmsp_pkg::PIXEL_W) ?
		3 * COLOR_BITS : lmsp_pkg::PIXEL_W;

	logic [EXT_W-1:0]      pix_ext;
	logic [COLOR_BITS-1:0] red;
	logic [COLOR_BITS-1:0] green;
	logic [COLOR_BITS-1:0] blue;

	// high color bits missing from the pixel read as zero
	assign pix_ext = EXT_W'(pixel);
	assign red     = pix_ext[2*COLOR_BITS +: COLOR_BITS];
	assign green   = pix_ext[COLOR_BITS +: COLOR_BITS];
	assign blue    = pix_ext[0 +: COLOR_BITS];

	// value >= slice + 1
	assign lit[0] = red > slice;
	assign lit[1] = green > slice;
	assign lit[2] = blue > slice;

endmodule
